@@ hdl/pba_pkg.sv @@
// Shared types and codes for the paragraph block allocator.
// Holds the header word layout, the result record and the function and error codes.
// No dependencies.
package pba_pkg;

   // Width of chain offsets; covers an arena of up to 65536 paragraphs plus one block step
   localparam int OFF_W = 18;

   // Block header as stored per paragraph
   typedef struct packed {
      logic        valid;
      logic        last;
      logic        used;
      logic [15:0] size;
   } hdr_type;

   // Function codes of a request
   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_FREE   = 2'd1;
   localparam logic [1:0] FUNC_RESIZE = 2'd2;

   // Error codes of a response
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_NOMEM  = 2'd1;
   localparam logic [1:0] ERR_BADBLK = 2'd2;

   // One response
   typedef struct packed {
      logic        ok;
      logic [1:0]  error_code;
      logic [15:0] granted_segment;
      logic [15:0] largest_free;
   } rsp_type;

endpackage

@@ hdl/pba_hdr_mem.sv @@
// Header store of the paragraph block allocator.
// One write port and one read port with registered read data; uses pba_pkg.
module pba_hdr_mem #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                clock,
   input  logic [ADDR_W-1:0]   rd_addr,
   output pba_pkg::hdr_type    rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  pba_pkg::hdr_type    wr_data
);
   import pba_pkg::*;

   hdr_type mem [DEPTH];
   hdr_type rd_data_ff;

   // Write one header, read one header each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pba_ctrl.sv @@
// Sequencer of the paragraph block allocator: clearing pass, chain walk,
// free and resize, write-back queue and response register. Uses pba_pkg.
module pba_ctrl #(
   parameter int BASE_SEGMENT = 1792,
   parameter int ARENA_PARAS  = 4096,
   parameter int IDX_W        = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [15:0]        req_request_paras,
   input  logic [15:0]        req_block_segment,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pba_pkg::rsp_type   rsp_data,
   output logic [IDX_W-1:0]   mem_rd_addr,
   input  pba_pkg::hdr_type   mem_rd_data,
   output logic               mem_wr_en,
   output logic [IDX_W-1:0]   mem_wr_addr,
   output pba_pkg::hdr_type   mem_wr_data
);
   import pba_pkg::*;

   localparam logic [OFF_W-1:0] ARENA_OFF = OFF_W'(ARENA_PARAS);
   localparam logic [IDX_W-1:0] CLR_LAST  = IDX_W'(ARENA_PARAS - 1);
   localparam logic [16:0]      BASE_X    = 17'(BASE_SEGMENT);
   localparam logic [15:0]      INIT_SIZE = 16'(ARENA_PARAS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOCATE, ST_LOOK, ST_FREE_NX, ST_GROW,
      ST_ALLOC_CHK, ST_ALLOC_END, ST_WR, ST_DONE
   } state_type;

   state_type          state_ff;
   logic [IDX_W-1:0]   clr_ff;
   logic [1:0]         func_ff;
   logic [15:0]        req_ff;
   logic [15:0]        blk_ff;
   logic [OFF_W-1:0]   off_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   best_ff;
   logic [15:0]        bsize_ff;
   hdr_type            bw_ff;
   logic [15:0]        largest_ff;
   logic [IDX_W-1:0]   h_ff;
   hdr_type            w_ff;
   logic [OFF_W-1:0]   nidx_ff;
   logic [OFF_W-1:0]   q_addr_ff [3];
   hdr_type            q_data_ff [3];
   logic [1:0]         wr_cnt_ff;
   logic [1:0]         wr_idx_ff;
   rsp_type            res_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   // Combinational helpers
   hdr_type            rw;
   logic [OFF_W-1:0]   reqx;
   logic [OFF_W-1:0]   rsz;
   logic [OFF_W-1:0]   off_next;
   logic [OFF_W-1:0]   hx;
   logic [OFF_W-1:0]   bestx;
   logic [OFF_W-1:0]   nidx;
   logic [OFF_W-1:0]   comb;
   logic [15:0]        hs;
   logic [16:0]        rel;
   logic               loc_ok;
   logic               n_ok;
   logic               take;

   always_comb begin
      rw       = mem_rd_data;
      reqx     = OFF_W'(req_ff);
      rsz      = OFF_W'(rw.size);
      off_next = off_ff + rsz + OFF_W'(1);
      hx       = OFF_W'(h_ff);
      bestx    = OFF_W'(best_ff);
      nidx     = hx + rsz + OFF_W'(1);
      comb     = OFF_W'(w_ff.size) + OFF_W'(1) + rsz;
      hs       = blk_ff - 16'd1;
      rel      = {1'b0, hs} - BASE_X;
      loc_ok   = ({1'b0, hs} >= BASE_X) && (OFF_W'(rel) < ARENA_OFF);
      n_ok     = rw.valid && !rw.used && (nidx_ff < ARENA_OFF);
      take     = !rw.used && (rw.size >= req_ff) && (!found_ff || rw.size < bsize_ff);
   end

   // Drive the header store ports
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_ff;
      mem_wr_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            if (clr_ff == '0) begin
               mem_wr_data = '{valid: 1'b1, last: 1'b1, used: 1'b0, size: INIT_SIZE};
            end
         end
         ST_WR: begin
            mem_wr_en   = q_addr_ff[wr_idx_ff] < ARENA_OFF;
            mem_wr_addr = q_addr_ff[wr_idx_ff][IDX_W-1:0];
            mem_wr_data = q_data_ff[wr_idx_ff];
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_LOCATE:    mem_rd_addr = rel[IDX_W-1:0];
         ST_LOOK:      mem_rd_addr = nidx[IDX_W-1:0];
         ST_ALLOC_CHK: mem_rd_addr = off_next[IDX_W-1:0];
         default:      mem_rd_addr = '0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         wr_idx_ff    <= '0;
         wr_cnt_ff    <= '0;
      end else begin
         // Drop the response once taken, unless a new one replaces it
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            // Sweep the store once after reset
            ST_CLEAR: begin
               clr_ff <= clr_ff + IDX_W'(1);
               if (clr_ff == CLR_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            // Take a request
            ST_IDLE: begin
               if (req_valid) begin
                  func_ff    <= req_func;
                  req_ff     <= req_request_paras;
                  blk_ff     <= req_block_segment;
                  res_ff     <= '0;
                  off_ff     <= '0;
                  found_ff   <= 1'b0;
                  largest_ff <= '0;
                  wr_idx_ff  <= '0;
                  if (req_func == FUNC_ALLOC) begin
                     state_ff <= ST_ALLOC_CHK;
                  end else if (req_func == FUNC_FREE || req_func == FUNC_RESIZE) begin
                     state_ff <= ST_LOCATE;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            // Walk the chain, one header per cycle
            ST_ALLOC_CHK: begin
               if (!rw.valid) begin
                  state_ff <= ST_ALLOC_END;
               end else begin
                  if (!rw.used && rw.size > largest_ff) begin
                     largest_ff <= rw.size;
                  end
                  if (take) begin
                     found_ff <= 1'b1;
                     best_ff  <= off_ff[IDX_W-1:0];
                     bsize_ff <= rw.size;
                     bw_ff    <= rw;
                  end
                  if (rw.last || off_next >= ARENA_OFF) begin
                     state_ff <= ST_ALLOC_END;
                  end else begin
                     off_ff <= off_next;
                  end
               end
            end
            // Claim the best fit, splitting off the tail when it is large enough; else report no memory
            ST_ALLOC_END: begin
               if (found_ff) begin
                  res_ff.ok              <= 1'b1;
                  res_ff.granted_segment <= 16'(BASE_SEGMENT) + 16'(best_ff) + 16'd1;
                  if (OFF_W'(bsize_ff) > reqx + OFF_W'(1)) begin
                     q_addr_ff[0] <= bestx + reqx + OFF_W'(1);
                     q_data_ff[0] <= '{valid: 1'b1, last: bw_ff.last, used: 1'b0,
                                       size: bsize_ff - req_ff - 16'd1};
                     q_addr_ff[1] <= bestx;
                     q_data_ff[1] <= '{valid: 1'b1, last: 1'b0, used: 1'b1, size: req_ff};
                     wr_cnt_ff    <= 2'd2;
                  end else begin
                     q_addr_ff[0] <= bestx;
                     q_data_ff[0] <= '{valid: 1'b1, last: bw_ff.last, used: 1'b1,
                                       size: bw_ff.size};
                     wr_cnt_ff    <= 2'd1;
                  end
                  state_ff <= ST_WR;
               end else begin
                  res_ff.error_code   <= ERR_NOMEM;
                  res_ff.largest_free <= largest_ff;
                  state_ff            <= ST_DONE;
               end
            end
            // Find the header paragraph of the segment, or report a bad block outside the arena
            ST_LOCATE: begin
               if (loc_ok) begin
                  h_ff     <= rel[IDX_W-1:0];
                  state_ff <= ST_LOOK;
               end else begin
                  res_ff.error_code <= ERR_BADBLK;
                  state_ff          <= ST_DONE;
               end
            end
            // Check the header and start the free or resize
            ST_LOOK: begin
               w_ff    <= rw;
               nidx_ff <= nidx;
               if (!rw.valid) begin
                  res_ff.error_code <= ERR_BADBLK;
                  state_ff          <= ST_DONE;
               end else if (func_ff == FUNC_FREE) begin
                  res_ff.ok    <= 1'b1;
                  q_addr_ff[0] <= hx;
                  q_data_ff[0] <= '{valid: 1'b1, last: rw.last, used: 1'b0, size: rw.size};
                  wr_cnt_ff    <= 2'd1;
                  state_ff     <= rw.last ? ST_WR : ST_FREE_NX;
               end else if (rw.size >= req_ff) begin
                  res_ff.ok <= 1'b1;
                  if (rsz > reqx + OFF_W'(1)) begin
                     q_addr_ff[0] <= hx + reqx + OFF_W'(1);
                     q_data_ff[0] <= '{valid: 1'b1, last: rw.last, used: 1'b0,
                                       size: rw.size - req_ff - 16'd1};
                     q_addr_ff[1] <= hx;
                     q_data_ff[1] <= '{valid: 1'b1, last: 1'b0, used: rw.used, size: req_ff};
                     wr_cnt_ff    <= 2'd2;
                     state_ff     <= ST_WR;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end else begin
                  res_ff.error_code <= ERR_NOMEM;
                  state_ff          <= rw.last ? ST_DONE : ST_GROW;
               end
            end
            // Merge a freed block with a free successor
            ST_FREE_NX: begin
               if (n_ok) begin
                  q_addr_ff[1] <= nidx_ff;
                  q_data_ff[1] <= '0;
                  q_addr_ff[2] <= hx;
                  q_data_ff[2] <= '{valid: 1'b1, last: rw.last, used: 1'b0,
                                    size: w_ff.size + rw.size + 16'd1};
                  wr_cnt_ff    <= 2'd3;
               end
               state_ff <= ST_WR;
            end
            // Grow into a free successor
            ST_GROW: begin
               if (n_ok && comb >= reqx) begin
                  res_ff.ok         <= 1'b1;
                  res_ff.error_code <= ERR_NONE;
                  q_addr_ff[0]      <= nidx_ff;
                  q_data_ff[0]      <= '0;
                  if (comb > reqx + OFF_W'(1)) begin
                     q_addr_ff[1] <= hx + reqx + OFF_W'(1);
                     q_data_ff[1] <= '{valid: 1'b1, last: rw.last, used: 1'b0,
                                       size: comb[15:0] - req_ff - 16'd1};
                     q_addr_ff[2] <= hx;
                     q_data_ff[2] <= '{valid: 1'b1, last: 1'b0, used: w_ff.used, size: req_ff};
                     wr_cnt_ff    <= 2'd3;
                  end else begin
                     q_addr_ff[1] <= hx;
                     q_data_ff[1] <= '{valid: 1'b1, last: rw.last, used: w_ff.used,
                                       size: comb[15:0]};
                     wr_cnt_ff    <= 2'd2;
                  end
                  state_ff <= ST_WR;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            // Drain the write-back queue in order
            ST_WR: begin
               if (wr_idx_ff == wr_cnt_ff - 2'd1) begin
                  state_ff <= ST_DONE;
               end else begin
                  wr_idx_ff <= wr_idx_ff + 2'd1;
               end
            end
            // Hand the response over once the output register is free
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTH
   // Store is written only by the clearing pass and the write-back queue
   a_wr_states: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_WR))
      else $error("header write outside clear or write-back");

   // An accepted request leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("request accepted without starting work");

   // A success never carries an error code
   a_ok_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.ok && rsp_ff.error_code != ERR_NONE))
      else $error("success with error code");

   // A granted segment only comes with success
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.granted_segment == 16'd0 || rsp_ff.ok))
      else $error("segment granted on failure");

   // Write-back queue never holds more than three entries and is never empty
   a_wr_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |-> (wr_cnt_ff != 2'd0 && wr_idx_ff < wr_cnt_ff))
      else $error("write-back index out of range");
`endif

endmodule

@@ hdl/paragraph_block_allocator.sv @@
// Top level of the paragraph block allocator.
// Instantiates pba_ctrl and pba_hdr_mem; uses pba_pkg.
//
//   channel  ports                                        direction
//   req      req_valid/req_stall, func, paras, segment    in
//   rsp      rsp_valid/rsp_stall, ok, error, granted, free out
//
// Allocate walks the chain with one store read per header, then claims the best fit
// and drains up to two write-backs. Free and resize locate and check the header, then
// drain up to three write-backs; an unknown function goes straight to the response.
// After reset a clearing pass writes every header of the store before the first request.
// One request is in work at a time; a response waits in its register under rsp_stall.
module paragraph_block_allocator #(
   parameter int BASE_SEGMENT = 1792,
   parameter int ARENA_PARAS  = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_request_paras,
   input  logic [15:0] req_block_segment,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_granted_segment,
   output logic [15:0] rsp_largest_free
);
   import pba_pkg::*;

   localparam int IDX_W = $clog2(ARENA_PARAS);

   logic [IDX_W-1:0] mem_rd_addr;
   hdr_type          mem_rd_data;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   hdr_type          mem_wr_data;
   rsp_type          rsp_data;

   pba_ctrl #(
      .BASE_SEGMENT (BASE_SEGMENT),
      .ARENA_PARAS  (ARENA_PARAS),
      .IDX_W        (IDX_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_request_paras (req_request_paras),
      .req_block_segment (req_block_segment),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data)
   );

   pba_hdr_mem #(
      .DEPTH  (ARENA_PARAS),
      .ADDR_W (IDX_W)
   ) u_hdr_mem (
      .clock   (clock),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Unpack the response record
   assign rsp_ok              = rsp_data.ok;
   assign rsp_error_code      = rsp_data.error_code;
   assign rsp_granted_segment = rsp_data.granted_segment;
   assign rsp_largest_free    = rsp_data.largest_free;

endmodule
